// ----- rtl/core/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types, constants and tables of the box filter downsampler
// ----------------------------------------------------------------------------
package bfd_pkg;

  // fixed by the field widths of the block
  localparam int unsigned CH_W           = 8;
  localparam int unsigned SUM_W          = 14;
  localparam int unsigned FACTOR_W       = 4;
  localparam int unsigned OUT_WIDTH_W    = 11;
  localparam int unsigned OUT_HEIGHT_W   = 13;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned SUB_W          = 3;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned PIX_W          = 3 * CH_W;

  localparam int unsigned MAX_FACTOR     = 8;
  localparam int unsigned MAX_OUT_HEIGHT = 4096;
  localparam int unsigned MAX_OUT_WIDTH  = 1024;

  // reciprocal of factor squared, scaled by 2**RECIP_SHIFT and rounded up;
  // exact for every 14-bit sum
  localparam int unsigned RECIP_SHIFT    = 21;
  localparam int unsigned RECIP_W        = 22;
  localparam int unsigned PROD_W         = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_TAB [MAX_FACTOR] = '{
    22'd2097152, 22'd524288, 22'd233017, 22'd131072,
    22'd83887,   22'd58255,  22'd42800,  22'd32768
  };

  // reset values of the configuration registers
  localparam logic [FACTOR_W-1:0]     FACTOR_RST     = 4'd1;
  localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST  = 11'd640;
  localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 13'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR     = 2'd0,
    CFG_OUT_WIDTH  = 2'd1,
    CFG_OUT_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [2:0]       sum3_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // input word accepted this cycle
    logic acc;       // accumulate column sum and write it back
    logic mul;       // multiply column sums by the reciprocal
    logic load;      // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic col_last;  // word on the input closes a block row segment
    logic row_last;  // latched segment closes a whole block
    logic out_free;  // result register can take a new word
  } dp_sts_t;

endpackage

// ----- rtl/core/box_filter_downsampler_core.sv -----
// ----------------------------------------------------------------------------
// box_filter_downsampler_core
// supersample resolve: averages factor x factor blocks of an rgb raster stream
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order on the slave stream, one word per pixel,
// and each output word is the per-channel average of one factor x factor block
// (sum divided by factor squared, truncated); factor 1 passes pixels through.
// tuser marks the first pixel of a frame and clears the position counters;
// tlast on the master side marks the last output pixel of a frame. A pixel
// that does not end a block row segment is just taken. A pixel that ends a
// segment adds an accumulate step, because the column sum is read from the
// one-port accumulator line and written back. A pixel that ends a whole
// block goes through read, accumulate, reciprocal multiply and result load,
// which waits while the result register is full and the master side stalls;
// the result register lets the next pixels be taken while a finished word waits.
// Registers on the config channel (index: field): 0 factor (1..8), 1 output
// width (1..MAX_OUT_WIDTH), 2 output height (1..4096); zero acts as one and
// larger values saturate. Write them only while the block is idle. The
// accumulator line has no reset; source width must be a multiple of factor.
// ----------------------------------------------------------------------------
module box_filter_downsampler_core #(
  parameter int unsigned MAX_OUT_WIDTH = bfd_pkg::MAX_OUT_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // source pixel stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [bfd_pkg::PIX_W-1:0]        s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic                             s_axis_tuser_i,  // frame_start
  // resolved pixel stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [bfd_pkg::PIX_W-1:0]        m_axis_tdata_o,  // red_out, green_out, blue_out
  output logic                             m_axis_tlast_o   // frame_last
);
  import bfd_pkg::*;

  // config registers, always ready
  logic [FACTOR_W-1:0]     factor_q;
  logic [OUT_WIDTH_W-1:0]  out_width_q;
  logic [OUT_HEIGHT_W-1:0] out_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     <= FACTOR_RST;
      out_width_q  <= OUT_WIDTH_RST;
      out_height_q <= OUT_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FACTOR:     factor_q     <= cfg_data_i[FACTOR_W-1:0];
        CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i[OUT_WIDTH_W-1:0];
        CFG_OUT_HEIGHT: out_height_q <= cfg_data_i[OUT_HEIGHT_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one pixel at a time, extra steps at segment and block ends
  bfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, sums, accumulator line, divide and result register
  bfd_datapath #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .factor_i         (factor_q),
    .out_width_i      (out_width_q),
    .out_height_i     (out_height_q),
    .in_data_i        (s_axis_tdata_i),
    .in_frame_start_i (s_axis_tuser_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_data_o       (m_axis_tdata_o),
    .out_last_o       (m_axis_tlast_o)
  );

endmodule

// ----- rtl/core/bfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfd_ctrl
// sequencer for the box filter downsampler datapath
// ----------------------------------------------------------------------------
module bfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfd_pkg::dp_sts_t sts_i,
  output bfd_pkg::dp_cmd_t cmd_o
);
  import bfd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.take = take;
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && sts_i.col_last) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.row_last ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_seg_end_goes_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && sts_i.col_last |=> state_q == ST_ACC)
    else $error("segment end did not start accumulation");

  a_block_end_goes_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC && sts_i.row_last |=> state_q == ST_MUL)
    else $error("block end did not start the divide");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result register overwritten while full");

endmodule

// ----- rtl/core/bfd_datapath.sv -----
// ----------------------------------------------------------------------------
// bfd_datapath
// position counters, sums, accumulator line, divide and result register
// ----------------------------------------------------------------------------
module bfd_datapath #(
  parameter int unsigned MAX_OUT_WIDTH = bfd_pkg::MAX_OUT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bfd_pkg::FACTOR_W-1:0]        factor_i,
  input  logic [bfd_pkg::OUT_WIDTH_W-1:0]     out_width_i,
  input  logic [bfd_pkg::OUT_HEIGHT_W-1:0]    out_height_i,
  input  logic [bfd_pkg::PIX_W-1:0]           in_data_i,
  input  logic                                in_frame_start_i,
  input  bfd_pkg::dp_cmd_t                    cmd_i,
  output bfd_pkg::dp_sts_t                    sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bfd_pkg::PIX_W-1:0]           out_data_o,
  output logic                                out_last_o
);
  import bfd_pkg::*;

  localparam int unsigned COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned CMP_W = 14;
  localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_OUT_WIDTH);

  // clamped last indices
  logic [SUB_W-1:0] f_m1;
  logic [COL_W-1:0] ow_m1;
  logic [ROW_W-1:0] oh_m1;
  logic [CMP_W-1:0] w_ext;

  always_comb begin
    if (factor_i == '0)                          f_m1 = '0;
    else if (factor_i > FACTOR_W'(MAX_FACTOR))   f_m1 = SUB_W'(MAX_FACTOR - 1);
    else                                         f_m1 = SUB_W'(factor_i - 1'b1);

    w_ext = CMP_W'(out_width_i);
    if (w_ext == '0)        ow_m1 = '0;
    else if (w_ext > MAXW)  ow_m1 = COL_W'(MAXW - 1'b1);
    else                    ow_m1 = COL_W'(w_ext - 1'b1);

    if (out_height_i == '0)                                 oh_m1 = '0;
    else if (out_height_i > OUT_HEIGHT_W'(MAX_OUT_HEIGHT))  oh_m1 = ROW_W'(MAX_OUT_HEIGHT - 1);
    else                                                    oh_m1 = ROW_W'(out_height_i - 1'b1);
  end

  // position and horizontal sum
  logic [SUB_W-1:0] sub_col_q, sub_row_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  sum3_t            hsum_q;

  logic [SUB_W-1:0] sc, sr;
  logic [COL_W-1:0] oc;
  logic [ROW_W-1:0] orw;
  sum3_t            hs_base, hs_new;
  logic             col_last, row_last, ocol_last, orow_last;

  always_comb begin
    sc      = in_frame_start_i ? '0 : sub_col_q;
    sr      = in_frame_start_i ? '0 : sub_row_q;
    oc      = in_frame_start_i ? '0 : out_col_q;
    orw     = in_frame_start_i ? '0 : out_row_q;
    hs_base = in_frame_start_i ? '0 : hsum_q;
    for (int c = 0; c < 3; c++) begin
      hs_new[c] = hs_base[c] + SUM_W'(in_data_i[c*CH_W +: CH_W]);
    end
    col_last  = sc >= f_m1;
    row_last  = sr >= f_m1;
    ocol_last = oc >= ow_m1;
    orow_last = orw >= oh_m1;
  end

  // latched segment info
  logic [COL_W-1:0] idx_q;
  logic             first_row_q, row_last_q, frame_last_q;
  sum3_t            line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_col_q <= '0;
      sub_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      hsum_q    <= '0;
    end else if (cmd_i.take) begin
      sub_row_q <= sr;
      out_col_q <= oc;
      out_row_q <= orw;
      if (!col_last) begin
        sub_col_q <= sc + 1'b1;
        hsum_q    <= hs_new;
      end else begin
        sub_col_q <= '0;
        hsum_q    <= '0;
        if (ocol_last) begin
          out_col_q <= '0;
          if (row_last) begin
            sub_row_q <= '0;
            out_row_q <= orow_last ? '0 : orw + 1'b1;
          end else begin
            sub_row_q <= sr + 1'b1;
          end
        end else begin
          out_col_q <= oc + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      idx_q        <= oc;
      first_row_q  <= (sr == '0);
      row_last_q   <= row_last;
      frame_last_q <= ocol_last & orow_last;
      line_q       <= hs_new;
    end
  end

  // accumulator line
  sum3_t col_mem_q [MAX_OUT_WIDTH];
  sum3_t rd_q, col_new, col_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_new[c] = first_row_q ? line_q[c] : rd_q[c] + line_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rd_q <= col_mem_q[oc];
    if (cmd_i.acc) begin
      col_mem_q[idx_q] <= col_new;
      col_q            <= col_new;
    end
  end

  // divide by factor squared through the reciprocal table
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_q [3];
  assign recip = RECIP_TAB[f_m1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(col_q[c]) * PROD_W'(recip);
      end
    end
  end

  logic [PIX_W-1:0]              avg;
  logic [PROD_W-RECIP_SHIFT-1:0] quo;

  always_comb begin
    avg = '0;
    quo = '0;
    for (int c = 0; c < 3; c++) begin
      quo = prod_q[c][PROD_W-1:RECIP_SHIFT];
      avg[c*CH_W +: CH_W] = (quo > (PROD_W-RECIP_SHIFT)'(255)) ? 8'hFF : quo[CH_W-1:0];
    end
  end

  // result register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_data_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= avg;
      out_last_q <= frame_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign sts_o.col_last = col_last;
  assign sts_o.row_last = row_last_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule

// ----- test/box_filter_downsampler_core_check.sv -----
// ----------------------------------------------------------------------------
// box_filter_downsampler_core_check
// watches the config, source and resolved streams and scores the resolved words
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers, the accumulator line and the block
// position, computes each block average when a source word closes a block and
// compares every resolved word against the oldest outstanding average.
// ----------------------------------------------------------------------------
module box_filter_downsampler_core_check import bfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [PIX_W-1:0]       s_tdata_i,   // red_in, green_in, blue_in
  input  logic                   s_tuser_i,   // frame_start
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [PIX_W-1:0]       m_tdata_i,   // red_out, green_out, blue_out
  input  logic                   m_tlast_i,   // frame_last
  output int unsigned            errors_o,
  output int unsigned            pending_o,
  output int unsigned            words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COL_W = $clog2(MAX_OUT_WIDTH);

  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;    // ch[0] red, ch[2] blue
    logic                 last;
  } rgb_word_t;

  logic [FACTOR_W-1:0]     factor_q;
  logic [OUT_WIDTH_W-1:0]  width_q;
  logic [OUT_HEIGHT_W-1:0] height_q;

  sum3_t                   col_sum [MAX_OUT_WIDTH];
  sum3_t                   hsum;
  logic [SUB_W-1:0]        sub_col;
  logic [SUB_W-1:0]        sub_row;
  logic [COL_W-1:0]        out_col;
  logic [ROW_W-1:0]        out_row;

  rgb_word_t               block_avgs [$];
  rgb_word_t               got;
  rgb_word_t               want;
  int unsigned             errors = 0;
  int unsigned             words  = 0;
  int                      k;

  initial begin
    for (k = 0; k < MAX_OUT_WIDTH; k++) col_sum[k] = '0;
    errors_o  = 0;
    pending_o = 0;
    words_o   = 0;
  end

  // zero acts as one, larger values saturate
  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic resolve_pixel(input logic [PIX_W-1:0] pix, input logic first);
    int unsigned f, ow, oh, idx, avg;
    bit          seg_end, blk_end, col_end, row_end;
    rgb_word_t   w;
    int          c;
    f  = clamp_reg(32'(factor_q), MAX_FACTOR);
    ow = clamp_reg(32'(width_q), MAX_OUT_WIDTH);
    oh = clamp_reg(32'(height_q), MAX_OUT_HEIGHT);
    if (first) begin
      sub_col = '0;
      sub_row = '0;
      out_col = '0;
      out_row = '0;
      hsum    = '0;
    end
    for (c = 0; c < 3; c++) hsum[c] = hsum[c] + sum_t'(pix[c*CH_W +: CH_W]);

    // a counter at or past its limit counts as last
    seg_end = 32'(sub_col) >= f - 1;
    blk_end = 32'(sub_row) >= f - 1;
    col_end = 32'(out_col) >= ow - 1;
    row_end = 32'(out_row) >= oh - 1;

    if (!seg_end) begin
      sub_col = sub_col + 1'b1;
      return;
    end

    idx = 32'(out_col);
    for (c = 0; c < 3; c++)
      col_sum[idx][c] = (sub_row == '0) ? hsum[c] : col_sum[idx][c] + hsum[c];
    hsum    = '0;
    sub_col = '0;

    if (blk_end) begin
      for (c = 0; c < 3; c++) begin
        avg     = 32'(col_sum[idx][c]) / (f * f);
        w.ch[c] = (avg > 255) ? '1 : avg[CH_W-1:0];
      end
      w.last = col_end && row_end;
      block_avgs.push_back(w);
    end

    if (col_end) begin
      out_col = '0;
      if (blk_end) begin
        sub_row = '0;
        out_row = row_end ? '0 : out_row + 1'b1;
      end else begin
        sub_row = sub_row + 1'b1;
      end
    end else begin
      out_col = out_col + 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      factor_q = FACTOR_RST;
      width_q  = OUT_WIDTH_RST;
      height_q = OUT_HEIGHT_RST;
      hsum     = '0;
      sub_col  = '0;
      sub_row  = '0;
      out_col  = '0;
      out_row  = '0;
      block_avgs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FACTOR:     factor_q = cfg_data_i[FACTOR_W-1:0];
          CFG_OUT_WIDTH:  width_q  = cfg_data_i[OUT_WIDTH_W-1:0];
          CFG_OUT_HEIGHT: height_q = cfg_data_i[OUT_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) resolve_pixel(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        got.ch   = m_tdata_i;
        got.last = m_tlast_i;
        words++;
        if (block_avgs.size() == 0) begin
          $display("%0t: resolved word %0d expected none actual %h last %b",
                   $time, words, m_tdata_i, m_tlast_i);
          errors++;
        end else begin
          want = block_avgs.pop_front();
          for (k = 0; k < 3; k++) begin
            if (got.ch[k] !== want.ch[k]) begin
              $display("%0t: resolved word %0d %s expected %0d actual %0d", $time, words,
                       (k == 0) ? "red" : (k == 1) ? "green" : "blue", want.ch[k], got.ch[k]);
              errors++;
            end
          end
          if (got.last !== want.last) begin
            $display("%0t: resolved word %0d frame_last expected %b actual %b",
                     $time, words, want.last, got.last);
            errors++;
          end
        end
      end
    end
    errors_o  <= errors;
    pending_o <= block_avgs.size();
    words_o   <= words;
  end

endmodule

// ----- test/box_filter_downsampler_core_test.sv -----
// ----------------------------------------------------------------------------
// box_filter_downsampler_core_test
// stimulus and verdict for the box filter downsampler
// ----------------------------------------------------------------------------
// Drives source pixels and register writes into the block, throttles the
// resolved stream, and leaves all scoring to the checker beside the block.
// A short hand-built part covers pass-through, channel extremes, truncation
// and zero register values; random frames then sweep every factor, saturated
// registers, mid-frame register changes and a long output stall.
// ----------------------------------------------------------------------------
module box_filter_downsampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfd_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RST_CYCLES   = 12;
  // covers the read, accumulate, multiply and load steps of any word in flight
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_LIMIT  = 200000;
  localparam int unsigned TIMEOUT_NS   = 5000000;

  // index 3 is not a register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata   = '0;   // red_in, green_in, blue_in
  logic                  s_tuser   = 1'b0; // frame_start
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [PIX_W-1:0]      m_tdata;          // red_out, green_out, blue_out
  logic                  m_tlast;          // frame_last

  int unsigned errors;
  int unsigned pending;
  int unsigned words;

  // throttling, set between phases
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // one long output stall, requested by the stimulus, counted by the receiver
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned pixels = 0;
  int unsigned writes = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  box_filter_downsampler_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  box_filter_downsampler_core_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .errors_o    (errors),
    .pending_o   (pending),
    .words_o     (words)
  );

  // receiver: random back-pressure, or a long hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic set_idle(input int unsigned tx, input int unsigned rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // leaves cfg_valid high so back-to-back writes never lower and raise it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    writes++;
  endtask

  // only called while the block is idle
  task automatic configure(input logic [CFG_DATA_W-1:0] f, w, h, input bit spare);
    cfg_write(CFG_FACTOR, f);
    cfg_write(CFG_OUT_WIDTH, w);
    cfg_write(CFG_OUT_HEIGHT, h);
    if (spare) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // pix packs blue, green, red from the top down
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    pixels++;
  endtask

  // stop offering, wait for every outstanding block average, then let the
  // last segment write-back settle
  task automatic wait_drained();
    int unsigned n;
    s_tvalid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < DRAIN_LIMIT);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // one setting, n random pixels; start forces frame_start on the first pixel,
  // a nonzero frame_len on every frame boundary, noise_pct sprinkles stray ones
  task automatic run_phase(input logic [CFG_DATA_W-1:0] f, w, h, input bit start,
                           input int unsigned frame_len, n, noise_pct);
    int unsigned i;
    bit          fs;
    configure(f, w, h, 1'b0);
    for (i = 0; i < n; i++) begin
      fs = (start && i == 0) || (frame_len != 0 && i % frame_len == 0) ||
           ($urandom_range(99) < noise_pct);
      send_pixel(PIX_W'($urandom), fs);
    end
    wait_drained();
  endtask

  initial begin
    set_idle(33, 46);
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through at the reset settings, channel extremes
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h0000FF, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'hA555AA, 1'b0);
    wait_drained();

    // 2x2 blocks, two columns, one row: a saturated block, then one whose
    // sums 3, 4, 3 truncate to 0, 1, 0; the second word ends the frame
    configure(13'd2, 13'd2, 13'd1, 1'b0);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h030201, 1'b0);
    send_pixel(24'h000201, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000000, 1'b0);
    wait_drained();

    // zero registers act as one: every pixel is a whole frame
    configure(13'd0, 13'd0, 13'd0, 1'b1);
    send_pixel(24'h563412, 1'b1);
    send_pixel(24'h8001FE, 1'b0);
    send_pixel(24'h00FF7F, 1'b0);
    wait_drained();

    // frames wrap without frame_start
    run_phase(13'd2, 13'd3, 13'd2, 1'b1, 0, 72, 0);
    // factor field all ones plus garbage above it, saturates to eight
    run_phase(13'h1FFF, 13'd2, 13'd1, 1'b1, 128, 128, 0);
    // stop mid block row (segment 13 of 3x3, five columns) and shrink all
    // three registers so every position counter sits at or past its new limit
    run_phase(13'd3, 13'd5, 13'd3, 1'b1, 135, 41, 0);
    run_phase(13'd2, 13'd3, 13'd1, 1'b0, 0, 60, 0);

    set_idle(46, 33);
    // pass-through on the widest row setting, width register saturates; every
    // pixel closes a block, so the receiver stall backs up into the source
    hold_req <= 1'b1;
    run_phase(13'd1, 13'd2047, 13'd1, 1'b1, 1024, 512, 0);
    run_phase(13'd4, 13'd1, 13'd8191, 1'b1, 65536, 64, 0);
    // stray frame starts restart the frame at random
    run_phase(13'd5, 13'd2, 13'd1, 1'b1, 50, 100, 2);

    set_idle(0, 0);
    run_phase(13'd6, 13'd1, 13'd2, 1'b1, 72, 72, 0);
    run_phase(13'd7, 13'd1, 13'd1, 1'b1, 49, 49, 0);
    run_phase(13'd1, 13'd3, 13'd2, 1'b1, 6, 100, 5);

    if (pending != 0) $display("%0t: %0d block averages never resolved", $time, pending);
    $display("covered %0d source pixels, %0d resolved words, %0d register writes",
             pixels, words, writes);
    $display("factors 1..8, zero and saturated registers, mid-frame changes, long stall");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule
